FILE: rtl/tlb_fifo_lru_replacement_macros.svh
// Assertion macros for the TLB RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TLB_FIFO_LRU_REPLACEMENT_MACROS_SVH
`define TLB_FIFO_LRU_REPLACEMENT_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is asserted.
`define TFL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/tfl_pkg.sv
// Package for the fully associative TLB: field widths, codes and the item type.
// Depends on nothing; used by tfl_cell and tlb_fifo_lru_replacement.
`timescale 1ns / 1ps
`default_nettype none

package tfl_pkg;

  localparam int PAGE_W  = 32;
  localparam int PROC_W  = 16;
  localparam int FRAME_W = 16;
  localparam int COUNT_W = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd1;

  // Item modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Replacement policies.
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  // Key and frame of the item being processed, broadcast to every cell.
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [PROC_W-1:0]  proc;
    logic [FRAME_W-1:0] frame;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/tfl_cell.sv
// One TLB entry of the cell row: stores the entry, refines the search beat passing through.
// Depends on tfl_pkg; instantiated by tlb_fifo_lru_replacement.
`timescale 1ns / 1ps
`default_nettype none

module tfl_cell #(
  parameter int MAX_ENTRIES = 32,
  parameter int CELL_IDX    = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tfl_pkg::item_t item_i,
  input  wire logic          policy_i,
  input  wire logic [7*((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)+
                     tfl_pkg::FRAME_W+4-1:0] tok_i,
  output logic      [7*((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)+
                     tfl_pkg::FRAME_W+4-1:0] tok_o,
  input  wire logic [4*((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)+4-1:0] cmd_i
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AgeW = IdxW;

  typedef struct packed {
    logic                        vld;
    logic                        hit;
    logic [AgeW-1:0]             m_iage;
    logic [AgeW-1:0]             m_uage;
    logic [tfl_pkg::FRAME_W-1:0] m_frame;
    logic [IdxW-1:0]             m_idx;
    logic                        fr_ok;
    logic [IdxW-1:0]             fr_idx;
    logic                        vc_ok;
    logic [IdxW-1:0]             vc_idx;
    logic [AgeW-1:0]             vc_iage;
    logic [AgeW-1:0]             vc_uage;
  } tok_t;

  typedef struct packed {
    logic            wr_en;
    logic            rec_en;
    logic [IdxW-1:0] wr_idx;
    logic [AgeW-1:0] new_age;
    logic            dec_i_en;
    logic [AgeW-1:0] dec_i_thr;
    logic            dec_u_en;
    logic [AgeW-1:0] dec_u_thr;
  } cmd_t;

  tok_t tok_in, tok_d, tok_q;
  cmd_t cmd;

  logic                          valid_q;
  logic [tfl_pkg::PAGE_W-1:0]    page_q;
  logic [tfl_pkg::PROC_W-1:0]    proc_q;
  logic [tfl_pkg::FRAME_W-1:0]   frame_q;
  logic [AgeW-1:0]               iage_q;
  logic [AgeW-1:0]               uage_q;

  logic            match;
  logic            sel;
  logic [AgeW-1:0] vage;

  assign tok_in = tok_t'(tok_i);
  assign cmd    = cmd_t'(cmd_i);
  assign tok_o  = tok_q;
  assign sel    = (cmd.wr_idx == IdxW'(CELL_IDX));

  // Search step: oldest matching entry, first free slot, rank-zero victim.
  always_comb begin
    tok_d = tok_in;
    match = valid_q && (page_q == item_i.page) && (proc_q == item_i.proc);
    vage  = (policy_i == tfl_pkg::POL_LRU) ? uage_q : iage_q;
    if (match && (!tok_in.hit || (iage_q < tok_in.m_iage))) begin
      tok_d.hit     = 1'b1;
      tok_d.m_iage  = iage_q;
      tok_d.m_uage  = uage_q;
      tok_d.m_frame = frame_q;
      tok_d.m_idx   = IdxW'(CELL_IDX);
    end
    if (!valid_q && !tok_in.fr_ok) begin
      tok_d.fr_ok  = 1'b1;
      tok_d.fr_idx = IdxW'(CELL_IDX);
    end
    if (valid_q && !tok_in.vc_ok && (vage == '0)) begin
      tok_d.vc_ok   = 1'b1;
      tok_d.vc_idx  = IdxW'(CELL_IDX);
      tok_d.vc_iage = iage_q;
      tok_d.vc_uage = uage_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (cmd.wr_en && sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.wr_en && sel) begin
      page_q  <= item_i.page;
      proc_q  <= item_i.proc;
      frame_q <= item_i.frame;
      iage_q  <= cmd.new_age;
      uage_q  <= cmd.new_age;
    end else begin
      if (cmd.dec_i_en && valid_q && (iage_q > cmd.dec_i_thr)) begin
        iage_q <= iage_q - AgeW'(1);
      end
      if (cmd.rec_en && sel) begin
        uage_q <= cmd.new_age;
      end else if (cmd.dec_u_en && valid_q && (uage_q > cmd.dec_u_thr)) begin
        uage_q <= uage_q - AgeW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlb_fifo_lru_replacement.sv
// Top level of the fully associative TLB with FIFO or LRU replacement.
// Depends on tfl_pkg, tfl_cell and tlb_fifo_lru_replacement_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_fifo_lru_replacement_macros.svh"

// Usage.
// An item is taken when start_i is high and busy_o is low. A lookup
// (mode_i low) gives one result beat: done_o is high for exactly one cycle
// with hit_o and frame_out_o, frame_out_o being zero on a miss. An insert
// (mode_i high) gives no result beat. The receiver cannot hold results off.
// The entries live in a row of MAX_ENTRIES cells. A search beat enters the
// first cell in the cycle after acceptance and moves one cell per cycle;
// each cell folds its own entry into it. When the beat leaves the last
// cell the update (recency refresh, append or replacement) is broadcast
// to all cells at once and a lookup result is registered; busy_o falls
// as well, so the next item is taken only after the previous one has
// walked the whole cell row, for lookups and inserts alike.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
// cfg_data_i) writes entry_count at index 0 and policy at index 1; it is
// ready whenever no item is in flight. Reset empties the TLB, sets
// entry_count to 32 and selects FIFO replacement.

module tlb_fifo_lru_replacement #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            mode_i,
  input  wire logic [tfl_pkg::PAGE_W-1:0]      page_number_i,
  input  wire logic [tfl_pkg::PROC_W-1:0]      process_id_i,
  input  wire logic [tfl_pkg::FRAME_W-1:0]     frame_in_i,
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic [tfl_pkg::FRAME_W-1:0]          frame_out_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tfl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tfl_pkg::COUNT_W-1:0]     cfg_data_i
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AgeW = IdxW;
  localparam int OccW = $clog2(MAX_ENTRIES + 1);

  // Search beat travelling along the cell row; same layout as in tfl_cell.
  typedef struct packed {
    logic                        vld;
    logic                        hit;
    logic [AgeW-1:0]             m_iage;
    logic [AgeW-1:0]             m_uage;
    logic [tfl_pkg::FRAME_W-1:0] m_frame;
    logic [IdxW-1:0]             m_idx;
    logic                        fr_ok;
    logic [IdxW-1:0]             fr_idx;
    logic                        vc_ok;
    logic [IdxW-1:0]             vc_idx;
    logic [AgeW-1:0]             vc_iage;
    logic [AgeW-1:0]             vc_uage;
  } tok_t;

  // Update broadcast to every cell when the search beat comes out.
  typedef struct packed {
    logic            wr_en;
    logic            rec_en;
    logic [IdxW-1:0] wr_idx;
    logic [AgeW-1:0] new_age;
    logic            dec_i_en;
    logic [AgeW-1:0] dec_i_thr;
    logic            dec_u_en;
    logic [AgeW-1:0] dec_u_thr;
  } cmd_t;

  logic                         busy_q, busy_d;
  logic                         launch_q;
  logic                         mode_q;
  tfl_pkg::item_t               item_q;
  logic [tfl_pkg::COUNT_W-1:0]  count_q;
  logic                         policy_q;
  logic [OccW-1:0]              occ_q, occ_d;
  logic                         done_q;
  logic                         hit_q;
  logic [tfl_pkg::FRAME_W-1:0]  frame_q;

  logic   accept;
  logic   room;
  tok_t   inject;
  tok_t   last;
  cmd_t   cmd;
  tok_t   chain [MAX_ENTRIES];

  assign accept      = start_i && !busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;
  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign frame_out_o = frame_q;

  always_comb begin
    inject     = '0;
    inject.vld = launch_q;
  end

  assign last = chain[MAX_ENTRIES-1];

  // The cell row. Cell 0 takes the launched beat, each other cell that of its left neighbour.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    tok_t tok_in;
    if (g == 0) begin : g_head
      assign tok_in = inject;
    end else begin : g_body
      assign tok_in = chain[g-1];
    end
    tfl_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .item_i  (item_q),
      .policy_i(policy_q),
      .tok_i   (tok_in),
      .tok_o   (chain[g]),
      .cmd_i   (cmd)
    );
  end

  // There is room to append while occupancy is below both the
  // configured count and the physical capacity.
  assign room = (32'(occ_q) < 32'(count_q)) && (32'(occ_q) < MAX_ENTRIES);

  // Decide the update once the beat has seen every entry.
  always_comb begin
    cmd    = '0;
    occ_d  = occ_q;
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (last.vld) begin
      busy_d = 1'b0;
      if (mode_q == tfl_pkg::MODE_LOOKUP) begin
        // In LRU mode a hit moves the entry to the top of the recency order.
        if (last.hit && (policy_q == tfl_pkg::POL_LRU)) begin
          cmd.rec_en    = 1'b1;
          cmd.wr_idx    = last.m_idx;
          cmd.new_age   = AgeW'(occ_q - OccW'(1));
          cmd.dec_u_en  = 1'b1;
          cmd.dec_u_thr = last.m_uage;
        end
      end else if (count_q != '0) begin
        if (room) begin
          if (last.fr_ok) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_idx  = last.fr_idx;
            cmd.new_age = AgeW'(occ_q);
            occ_d       = occ_q + OccW'(1);
          end
        end else if (last.vc_ok) begin
          // Full: the victim leaves, the ranks above it close the gap and
          // the new entry takes the top rank in both orders.
          cmd.wr_en     = 1'b1;
          cmd.wr_idx    = last.vc_idx;
          cmd.new_age   = AgeW'(occ_q - OccW'(1));
          cmd.dec_i_en  = 1'b1;
          cmd.dec_i_thr = last.vc_iage;
          cmd.dec_u_en  = 1'b1;
          cmd.dec_u_thr = last.vc_uage;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      occ_q    <= '0;
      count_q  <= tfl_pkg::COUNT_RESET;
      policy_q <= tfl_pkg::POL_FIFO;
    end else begin
      busy_q   <= busy_d;
      launch_q <= accept;
      done_q   <= last.vld && (mode_q == tfl_pkg::MODE_LOOKUP);
      occ_q    <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tfl_pkg::CFG_ENTRY_COUNT: begin
            count_q <= cfg_data_i;
          end
          tfl_pkg::CFG_POLICY: begin
            policy_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_i;
      item_q.page  <= page_number_i;
      item_q.proc  <= process_id_i;
      item_q.frame <= frame_in_i;
    end
    if (last.vld) begin
      hit_q   <= last.hit;
      frame_q <= last.hit ? last.m_frame : '0;
    end
  end

  `TFL_ASSERT(a_done_follows_beat, clk_i, rst_ni, done_q |-> $past(last.vld), "result beat without a finished search")
  `TFL_ASSERT_ALWAYS(a_idle_row_empty, clk_i, !busy_q |-> !last.vld && !launch_q, "search beat in flight while idle")
  `TFL_ASSERT(a_accept_launches, clk_i, rst_ni, accept |=> launch_q && busy_q, "accepted item did not enter the cell row")
  `TFL_ASSERT(a_occ_bound, clk_i, rst_ni, 32'(occ_q) <= MAX_ENTRIES, "occupancy beyond capacity")

endmodule

`default_nettype wire
